// File: hw/rtl/lmnf_pkg.sv
package lmnf_pkg;

    localparam int NUMBER_W   = 32;
    localparam int STYLE_W    = 3;
    localparam int CHAR_W     = 8;
    localparam int BUFLEN_W   = 7;
    localparam int DIGIT_W    = 5;
    localparam int NUM_DIGITS = 10;
    localparam int KIDX_W     = 4;
    localparam int COUNT_W    = 5;
    localparam int STEP_W     = 5;

    localparam logic [BUFLEN_W-1:0] BUFLEN_RESET = 7'd64;
    localparam logic [STEP_W-1:0]   STEP_LAST    = STEP_W'(NUMBER_W - 1);

    // style codes
    localparam logic [STYLE_W-1:0] STYLE_LOWER_ALPHA = 3'd1;
    localparam logic [STYLE_W-1:0] STYLE_UPPER_ALPHA = 3'd2;
    localparam logic [STYLE_W-1:0] STYLE_LOWER_ROMAN = 3'd3;
    localparam logic [STYLE_W-1:0] STYLE_UPPER_ROMAN = 3'd4;

    // range limits and bijective base-26 offsets
    localparam logic signed [NUMBER_W-1:0] ALPHA_MAX     = 32'sd18278;
    localparam logic signed [NUMBER_W-1:0] ALPHA_ONE_MAX = 32'sd26;
    localparam logic signed [NUMBER_W-1:0] ALPHA_TWO_MAX = 32'sd702;
    localparam logic signed [NUMBER_W-1:0] ROMAN_MAX     = 32'sd4999;
    localparam logic [NUMBER_W-1:0]        ALPHA_OFF1    = 32'd1;
    localparam logic [NUMBER_W-1:0]        ALPHA_OFF2    = 32'd27;
    localparam logic [NUMBER_W-1:0]        ALPHA_OFF3    = 32'd703;

    // radix constants for the digit vector
    localparam logic [DIGIT_W:0]   BASE10 = 6'd10;
    localparam logic [DIGIT_W:0]   BASE26 = 6'd26;
    localparam logic [DIGIT_W-1:0] HALF10 = 5'd5;
    localparam logic [DIGIT_W-1:0] HALF26 = 5'd13;

    // characters
    localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_STAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_CASE    = 8'h20;

    // roman symbol roles within one decimal place
    localparam logic [1:0] SYM_ONE  = 2'd0;
    localparam logic [1:0] SYM_FIVE = 2'd1;
    localparam logic [1:0] SYM_TEN  = 2'd2;

    typedef logic [DIGIT_W-1:0] digit_t;
    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_LEAD,
        ST_SIGN,
        ST_BODY,
        ST_DOT,
        ST_TERM
    } state_t;

    typedef enum logic [1:0] {
        MODE_DEC,
        MODE_ALPHA,
        MODE_ROMAN,
        MODE_STARS
    } mode_t;

    typedef struct packed {
        logic                load;
        logic                step;
        logic                base26;
        logic [NUMBER_W-1:0] value;
    } radix_ctrl_t;

    // number of symbols a digit takes in its place
    function automatic logic [2:0] roman_len(input logic [1:0] place, input digit_t d);
        logic [2:0] len;
        len = 3'd0;
        if (place == 2'd3)
        begin
            len = d[2:0];
        end
        else
        begin
            case (d)
                5'd1:    len = 3'd1;
                5'd2:    len = 3'd2;
                5'd3:    len = 3'd3;
                5'd4:    len = 3'd2;
                5'd5:    len = 3'd1;
                5'd6:    len = 3'd2;
                5'd7:    len = 3'd3;
                5'd8:    len = 3'd4;
                5'd9:    len = 3'd2;
                default: len = 3'd0;
            endcase
        end
        return len;
    endfunction

    function automatic logic [1:0] roman_sym(input digit_t d, input logic [2:0] pos);
        logic [1:0] sym;
        sym = SYM_ONE;
        case (d)
            5'd4:                      sym = (pos == 3'd0) ? SYM_ONE : SYM_FIVE;
            5'd5, 5'd6, 5'd7, 5'd8:    sym = (pos == 3'd0) ? SYM_FIVE : SYM_ONE;
            5'd9:                      sym = (pos == 3'd0) ? SYM_ONE : SYM_TEN;
            default:                   sym = SYM_ONE;
        endcase
        return sym;
    endfunction

    // upper-case letter for a symbol role in a place
    function automatic logic [CHAR_W-1:0] roman_letter(input logic [1:0] place,
                                                       input logic [1:0] sym);
        logic [CHAR_W-1:0] ch;
        ch = "M";
        case ({place, sym})
            {2'd0, SYM_ONE}:  ch = "I";
            {2'd0, SYM_FIVE}: ch = "V";
            {2'd0, SYM_TEN}:  ch = "X";
            {2'd1, SYM_ONE}:  ch = "X";
            {2'd1, SYM_FIVE}: ch = "L";
            {2'd1, SYM_TEN}:  ch = "C";
            {2'd2, SYM_ONE}:  ch = "C";
            {2'd2, SYM_FIVE}: ch = "D";
            {2'd2, SYM_TEN}:  ch = "M";
            default:          ch = "M";
        endcase
        return ch;
    endfunction

endpackage

// File: hw/rtl/lmnf_radix.sv
// shift-and-correct radix converter, one input bit per step, msb first
module lmnf_radix (
    input  logic                  clk,
    input  lmnf_pkg::radix_ctrl_t ctrl,
    output lmnf_pkg::digits_t     digits
);

    logic [lmnf_pkg::NUMBER_W-1:0]   value_reg;
    logic [lmnf_pkg::NUMBER_W-1:0]   value_next;
    lmnf_pkg::digits_t               digits_reg;
    lmnf_pkg::digits_t               digits_next;
    logic                            base26_reg;
    logic                            base26_next;
    logic [lmnf_pkg::NUM_DIGITS-1:0] ge;
    logic [lmnf_pkg::NUM_DIGITS-1:0] carry;
    logic [lmnf_pkg::DIGIT_W-1:0]    half;
    logic [lmnf_pkg::DIGIT_W:0]      base;
    logic [lmnf_pkg::DIGIT_W:0]      dbl;
    logic [lmnf_pkg::DIGIT_W:0]      sum;

    always_comb
    begin
        half = base26_reg ? lmnf_pkg::HALF26 : lmnf_pkg::HALF10;
        base = base26_reg ? lmnf_pkg::BASE26 : lmnf_pkg::BASE10;
        dbl  = '0;
        sum  = '0;
        carry[0] = value_reg[lmnf_pkg::NUMBER_W-1];
        for (int k = 0; k < lmnf_pkg::NUM_DIGITS; k++)
        begin
            ge[k] = (digits_reg[k] >= half);
        end
        for (int k = 0; k < lmnf_pkg::NUM_DIGITS - 1; k++)
        begin
            carry[k+1] = ge[k];
        end
        for (int k = 0; k < lmnf_pkg::NUM_DIGITS; k++)
        begin
            // double each digit, fold back the radix, take the carry from below
            dbl = {digits_reg[k], 1'b0};
            sum = (ge[k] ? (dbl - base) : dbl) + {{lmnf_pkg::DIGIT_W{1'b0}}, carry[k]};
            digits_next[k] = sum[lmnf_pkg::DIGIT_W-1:0];
        end
        value_next  = {value_reg[lmnf_pkg::NUMBER_W-2:0], 1'b0};
        base26_next = base26_reg;
        if (ctrl.load)
        begin
            value_next  = ctrl.value;
            digits_next = '0;
            base26_next = ctrl.base26;
        end
        else if (!ctrl.step)
        begin
            value_next  = value_reg;
            digits_next = digits_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        digits_reg <= digits_next;
        base26_reg <= base26_next;
    end

    assign digits = digits_reg;

endmodule

// File: hw/rtl/lmnf_ctrl.sv
// sequencer: input setup, conversion steps and character emission
module lmnf_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lmnf_pkg::NUMBER_W-1:0]   s_axis_tdata,
    input  logic [lmnf_pkg::STYLE_W-1:0]    s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lmnf_pkg::CHAR_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic [lmnf_pkg::BUFLEN_W-1:0]   cap,
    output lmnf_pkg::radix_ctrl_t           radix_ctrl,
    input  lmnf_pkg::digits_t               digits
);

    lmnf_pkg::state_t               state_reg, state_next;
    lmnf_pkg::mode_t                mode_reg, mode_next;
    logic                           neg_reg, neg_next;
    logic                           lower_reg, lower_next;
    logic [1:0]                     nlet_reg, nlet_next;
    logic [lmnf_pkg::STEP_W-1:0]    step_reg, step_next;
    logic [lmnf_pkg::KIDX_W-1:0]    k_reg, k_next;
    logic [2:0]                     p_reg, p_next;
    logic [lmnf_pkg::COUNT_W-1:0]   cnt_reg, cnt_next;
    logic                           out_valid_reg, out_valid_next;
    logic [lmnf_pkg::CHAR_W-1:0]    out_data_reg, out_data_next;
    logic                           out_last_reg, out_last_next;

    // input setup
    logic signed [lmnf_pkg::NUMBER_W-1:0] num;
    logic                                 in_neg;
    logic                                 is_alpha;
    logic                                 is_roman;
    logic [1:0]                           in_nlet;
    logic [lmnf_pkg::NUMBER_W-1:0]        sub_a;
    logic [lmnf_pkg::NUMBER_W-1:0]        sub_b;
    lmnf_pkg::mode_t                      in_mode;

    // emission
    logic                           advance;
    logic                           have;
    logic                           term_now;
    logic [lmnf_pkg::CHAR_W-1:0]    ch;
    lmnf_pkg::state_t               emit_state;
    logic [lmnf_pkg::KIDX_W-1:0]    emit_k;
    logic [2:0]                     emit_p;
    lmnf_pkg::digit_t               cur_digit;
    logic [2:0]                     rlen;
    logic [lmnf_pkg::KIDX_W-1:0]    lead;
    logic [lmnf_pkg::CHAR_W-1:0]    case_bit;

    always_comb
    begin
        num      = signed'(s_axis_tdata);
        in_neg   = num[lmnf_pkg::NUMBER_W-1];
        is_alpha = (s_axis_tuser == lmnf_pkg::STYLE_LOWER_ALPHA)
                || (s_axis_tuser == lmnf_pkg::STYLE_UPPER_ALPHA);
        is_roman = (s_axis_tuser == lmnf_pkg::STYLE_LOWER_ROMAN)
                || (s_axis_tuser == lmnf_pkg::STYLE_UPPER_ROMAN);

        // letters in use and the offset that makes the rest plain base 26
        sub_a = s_axis_tdata;
        if (in_neg || (num == '0))
        begin
            in_nlet = 2'd0;
            sub_a   = '0;
            sub_b   = '0;
        end
        else if (num <= lmnf_pkg::ALPHA_ONE_MAX)
        begin
            in_nlet = 2'd1;
            sub_b   = lmnf_pkg::ALPHA_OFF1;
        end
        else if (num <= lmnf_pkg::ALPHA_TWO_MAX)
        begin
            in_nlet = 2'd2;
            sub_b   = lmnf_pkg::ALPHA_OFF2;
        end
        else
        begin
            in_nlet = 2'd3;
            sub_b   = lmnf_pkg::ALPHA_OFF3;
        end

        if (is_alpha)
        begin
            in_mode = (num > lmnf_pkg::ALPHA_MAX) ? lmnf_pkg::MODE_STARS : lmnf_pkg::MODE_ALPHA;
        end
        else if (is_roman)
        begin
            in_mode = (in_neg || (num > lmnf_pkg::ROMAN_MAX)) ? lmnf_pkg::MODE_STARS
                                                              : lmnf_pkg::MODE_ROMAN;
            sub_a   = s_axis_tdata;
            sub_b   = '0;
        end
        else
        begin
            // decimal magnitude, negated through the same subtractor
            in_mode = lmnf_pkg::MODE_DEC;
            sub_a   = in_neg ? '0 : s_axis_tdata;
            sub_b   = in_neg ? s_axis_tdata : '0;
        end
    end

    always_comb
    begin
        lead = '0;
        for (int i = 1; i < lmnf_pkg::NUM_DIGITS; i++)
        begin
            if (digits[i] != '0)
            begin
                lead = lmnf_pkg::KIDX_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        neg_next       = neg_reg;
        lower_next     = lower_reg;
        nlet_next      = nlet_reg;
        step_next      = step_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;

        radix_ctrl        = '0;
        radix_ctrl.value  = sub_a - sub_b;
        radix_ctrl.base26 = is_alpha;

        s_axis_tready = (state_reg == lmnf_pkg::ST_IDLE);
        advance       = !out_valid_reg || m_axis_tready;
        term_now      = (state_reg == lmnf_pkg::ST_TERM)
                     || ({{(lmnf_pkg::BUFLEN_W - lmnf_pkg::COUNT_W){1'b0}}, cnt_reg} == cap);

        cur_digit = digits[k_reg];
        rlen      = lmnf_pkg::roman_len(k_reg[1:0], cur_digit);
        case_bit  = lower_reg ? lmnf_pkg::CHAR_CASE : '0;

        have       = 1'b0;
        ch         = lmnf_pkg::CHAR_NUL;
        emit_state = state_reg;
        emit_k     = k_reg;
        emit_p     = p_reg;

        case (state_reg)
            lmnf_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    radix_ctrl.load = 1'b1;
                    mode_next  = in_mode;
                    neg_next   = in_neg;
                    nlet_next  = in_nlet;
                    lower_next = (s_axis_tuser == lmnf_pkg::STYLE_LOWER_ALPHA)
                              || (s_axis_tuser == lmnf_pkg::STYLE_LOWER_ROMAN);
                    cnt_next   = '0;
                    step_next  = '0;
                    p_next     = '0;
                    k_next     = lmnf_pkg::KIDX_W'(3);
                    state_next = (in_mode == lmnf_pkg::MODE_STARS) ? lmnf_pkg::ST_BODY
                                                                    : lmnf_pkg::ST_CONV;
                end
            end
            lmnf_pkg::ST_CONV:
            begin
                radix_ctrl.step = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == lmnf_pkg::STEP_LAST)
                begin
                    state_next = lmnf_pkg::ST_LEAD;
                end
            end
            lmnf_pkg::ST_LEAD:
            begin
                p_next = '0;
                case (mode_reg)
                    lmnf_pkg::MODE_DEC:   k_next = lead;
                    lmnf_pkg::MODE_ALPHA: k_next = lmnf_pkg::KIDX_W'(2);
                    default:              k_next = lmnf_pkg::KIDX_W'(3);
                endcase
                state_next = ((mode_reg == lmnf_pkg::MODE_DEC) && neg_reg) ? lmnf_pkg::ST_SIGN
                                                                            : lmnf_pkg::ST_BODY;
            end
            lmnf_pkg::ST_SIGN:
            begin
                have       = 1'b1;
                ch         = lmnf_pkg::CHAR_MINUS;
                emit_state = lmnf_pkg::ST_BODY;
            end
            lmnf_pkg::ST_BODY:
            begin
                emit_k     = k_reg - 1'b1;
                emit_state = (k_reg == '0) ? lmnf_pkg::ST_DOT : lmnf_pkg::ST_BODY;
                case (mode_reg)
                    lmnf_pkg::MODE_DEC:
                    begin
                        have = 1'b1;
                        ch   = lmnf_pkg::CHAR_ZERO + {3'b000, cur_digit};
                    end
                    lmnf_pkg::MODE_ALPHA:
                    begin
                        have = 1'b1;
                        if (k_reg < {2'b00, nlet_reg})
                        begin
                            ch = (lower_reg ? lmnf_pkg::CHAR_LOWER_A : lmnf_pkg::CHAR_UPPER_A)
                               + {3'b000, cur_digit};
                        end
                        else
                        begin
                            ch = lmnf_pkg::CHAR_SPACE;
                        end
                    end
                    lmnf_pkg::MODE_ROMAN:
                    begin
                        // one symbol per beat; once the place has no symbols left, move to the next place
                        have       = (p_reg < rlen);
                        ch         = lmnf_pkg::roman_letter(k_reg[1:0],
                                         lmnf_pkg::roman_sym(cur_digit, p_reg)) | case_bit;
                        emit_state = lmnf_pkg::ST_BODY;
                        emit_k     = k_reg;
                        emit_p     = p_reg + 1'b1;
                        if (!have)
                        begin
                            p_next = '0;
                            if (k_reg == '0)
                            begin
                                state_next = lmnf_pkg::ST_DOT;
                            end
                            else
                            begin
                                k_next = k_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        have = 1'b1;
                        ch   = lmnf_pkg::CHAR_STAR;
                    end
                endcase
            end
            lmnf_pkg::ST_DOT:
            begin
                have       = 1'b1;
                ch         = lmnf_pkg::CHAR_DOT;
                emit_state = lmnf_pkg::ST_TERM;
            end
            lmnf_pkg::ST_TERM:
            begin
                have = 1'b1;
            end
            default:
            begin
                state_next = lmnf_pkg::ST_IDLE;
            end
        endcase

        if (have && advance)
        begin
            out_valid_next = 1'b1;
            if (term_now)
            begin
                out_data_next = lmnf_pkg::CHAR_NUL;
                out_last_next = 1'b1;
                state_next    = lmnf_pkg::ST_IDLE;
            end
            else
            begin
                out_data_next = ch;
                out_last_next = 1'b0;
                cnt_next      = cnt_reg + 1'b1;
                state_next    = emit_state;
                k_next        = emit_k;
                p_next        = emit_p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lmnf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            k_reg         <= '0;
            p_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            k_reg         <= k_next;
            p_reg         <= p_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg     <= mode_next;
        neg_reg      <= neg_next;
        lower_reg    <= lower_next;
        nlet_reg     <= nlet_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// File: hw/rtl/list_marker_number_formatter.sv
// list marker formatter: turns a signed item number into marker text
//
// input stream (s_axis): one beat per number, tdata is the number, tuser the
// list style (decimal, lower/upper alpha, lower/upper roman; other codes act
// as decimal). output stream (m_axis): one beat per ascii character, closed
// by a beat with character 0 and tlast high. cfg_we/cfg_wdata write the
// buffer length; at most buffer length minus one characters go out before
// the terminator. write it only while no number is in flight.
//
// timing: a number is taken when s_axis_tready is high, then a shared
// radix unit runs one step per input bit (base 10 or 26) and a lead step
// picks the leading digit (numbers shown as stars skip both); characters
// follow at one per cycle while the receiver takes them, and roman output
// pauses after each decimal place. ready drops for the whole item.
// the output beat sits in its own register: a stalled receiver holds the
// sequencer but the final beat may wait there while the next number is taken.
// reset clears the sequencer and the output valid and sets buffer length 64.
module list_marker_number_formatter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [lmnf_pkg::NUMBER_W-1:0]   s_axis_tdata,   // [31:0] number
    input  logic [lmnf_pkg::STYLE_W-1:0]    s_axis_tuser,   // [2:0] style
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lmnf_pkg::CHAR_W-1:0]     m_axis_tdata,   // [7:0] character
    output logic                            m_axis_tlast,   // is_last
    input  logic                            cfg_we,
    input  logic [lmnf_pkg::BUFLEN_W-1:0]   cfg_wdata       // buffer_length
);

    logic [lmnf_pkg::BUFLEN_W-1:0] buflen_reg;
    logic [lmnf_pkg::BUFLEN_W-1:0] buflen_next;
    logic [lmnf_pkg::BUFLEN_W-1:0] cap;
    lmnf_pkg::radix_ctrl_t         radix_ctrl;
    lmnf_pkg::digits_t             digits;

    // buffer length register
    always_comb
    begin
        buflen_next = cfg_we ? cfg_wdata : buflen_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buflen_reg <= lmnf_pkg::BUFLEN_RESET;
        end
        else
        begin
            buflen_reg <= buflen_next;
        end
    end

    // characters allowed before the terminator; zero length acts as one
    assign cap = (buflen_reg == '0) ? '0 : (buflen_reg - 1'b1);

    lmnf_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cap           (cap),
        .radix_ctrl    (radix_ctrl),
        .digits        (digits)
    );

    // shared radix unit: one shift-and-correct step per cycle
    lmnf_radix u_radix (
        .clk    (clk),
        .ctrl   (radix_ctrl),
        .digits (digits)
    );

endmodule

// File: hw/rtl/lmnf_checker.sv
module lmnf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [lmnf_pkg::CHAR_W-1:0] m_axis_tdata,
    input logic                        m_axis_tlast
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
        else $error("stalled output beat changed");

    // a taken number keeps the input closed while it is worked on
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready right after a number was taken");

    // nul appears exactly on the closing beat
    a_nul_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata == lmnf_pkg::CHAR_NUL) == m_axis_tlast))
        else $error("terminator and tlast disagree");

    // a new number only starts once the previous run has been closed
    a_take_after_close: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |-> (!m_axis_tvalid || m_axis_tlast))
        else $error("number taken while a run is still open");

endmodule

bind list_marker_number_formatter lmnf_checker u_lmnf_checker (.*);
